// File: hdl/sans_pkg.sv
// shared constants, field types and handshake structs for the sorted array neighbor search
`timescale 1ns / 1ps
`default_nettype none

package sans_pkg;

    localparam int DEPTH   = 1024;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IDX_W   = 10;
    localparam int KEY_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int BND_W   = IDX_W + 2;
    localparam int S_DATA_W = ((IDX_W + KEY_W + IDX_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((IDX_W + 7) / 8) * 8;

    localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LESSER  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_GREATER = 2'd2;

    typedef struct packed {
        logic                    want_greater;
        logic signed [KEY_W-1:0] target;
        logic [IDX_W-1:0]        window_low;
        logic [IDX_W-1:0]        window_high;
    } sans_req_t;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] position;
    } sans_res_t;

endpackage

`default_nettype wire

// File: hdl/sans_key_ram.sv
// key store: one write port, one read port with registered read data
`timescale 1ns / 1ps
`default_nettype none

module sans_key_ram (
    input  wire logic                             aclk,
    input  wire logic                             wr_en,
    input  wire logic [sans_pkg::ADDR_W-1:0]      wr_addr,
    input  wire logic signed [sans_pkg::KEY_W-1:0] wr_data,
    input  wire logic [sans_pkg::ADDR_W-1:0]      rd_addr,
    output logic signed [sans_pkg::KEY_W-1:0]     rd_data
);
    import sans_pkg::*;

    logic signed [KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: hdl/sans_search.sv
// binary search sequencer with shared signed less-than and greater-than compares against the key store
`timescale 1ns / 1ps
`default_nettype none

module sans_search (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              start_valid,
    output logic                                   start_ready,
    input  wire sans_pkg::sans_req_t               req,
    output logic [sans_pkg::ADDR_W-1:0]            rd_addr,
    input  wire logic signed [sans_pkg::KEY_W-1:0] rd_data,
    output logic                                   res_valid,
    input  wire logic                              res_ready,
    output sans_pkg::sans_res_t                    res
);
    import sans_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_READ = 4'b0010,
        S_CMP  = 4'b0100,
        S_DONE = 4'b1000
    } sans_state_t;

    localparam logic signed [BND_W-1:0] HI_MAX = BND_W'(DEPTH - 1);
    localparam logic signed [BND_W-1:0] ONE    = BND_W'(1);

    sans_state_t             state_reg, state_next;
    logic signed [BND_W-1:0] lo_reg, lo_next;
    logic signed [BND_W-1:0] hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic signed [KEY_W-1:0] target_reg, target_next;
    logic                    greater_reg, greater_next;
    logic                    found_reg, found_next;
    logic [IDX_W-1:0]        pos_reg, pos_next;

    logic signed [BND_W-1:0] span;
    logic signed [BND_W-1:0] mid_full;
    logic signed [BND_W-1:0] mid_ext;
    logic signed [BND_W-1:0] win_hi;
    logic                    key_lt;
    logic                    key_gt;

    assign span     = hi_reg - lo_reg + ONE;
    assign mid_full = lo_reg + (span >>> 1);
    assign mid_ext  = $signed({{(BND_W-ADDR_W){1'b0}}, mid_reg});
    assign win_hi   = ($signed({2'b00, req.window_high}) > HI_MAX) ? HI_MAX
                                                                   : $signed({2'b00, req.window_high});
    // shared signed less-than and greater-than compares
    assign key_lt   = rd_data < target_reg;
    assign key_gt   = rd_data > target_reg;

    assign start_ready = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.found    = found_reg;
    assign res.position = pos_reg;
    assign rd_addr      = ADDR_W'(mid_full);

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        mid_next     = mid_reg;
        target_next  = target_reg;
        greater_next = greater_reg;
        found_next   = found_reg;
        pos_next     = pos_reg;
        case (state_reg)
            S_IDLE: begin
                if (start_valid) begin
                    lo_next      = $signed({2'b00, req.window_low});
                    hi_next      = win_hi;
                    target_next  = req.target;
                    greater_next = req.want_greater;
                    found_next   = 1'b0;
                    pos_next     = '0;
                    state_next   = S_READ;
                end
            end
            S_READ: begin
                if (lo_reg <= hi_reg) begin
                    mid_next   = ADDR_W'(mid_full);
                    state_next = S_CMP;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_CMP: begin
                if (key_lt) begin
                    if (!greater_reg) begin
                        found_next = 1'b1;
                        pos_next   = IDX_W'(mid_reg);
                    end
                    lo_next = mid_ext + ONE;
                end else if (key_gt) begin
                    if (greater_reg) begin
                        found_next = 1'b1;
                        pos_next   = IDX_W'(mid_reg);
                    end
                    hi_next = mid_ext - ONE;
                end else if (greater_reg) begin
                    lo_next = mid_ext + ONE;
                end else begin
                    hi_next = mid_ext - ONE;
                end
                state_next = S_READ;
            end
            S_DONE: begin
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        target_reg  <= target_next;
        greater_reg <= greater_next;
        found_reg   <= found_next;
        pos_reg     <= pos_next;
    end

    a_mid_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |-> (mid_ext >= lo_reg) && (mid_ext <= hi_reg))
        else $error("probe index outside search window");

    a_window_shrinks: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |=> (hi_reg - lo_reg) < $past(hi_reg - lo_reg))
        else $error("search window did not shrink after a probe");

    a_miss_position_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && !res.found |-> res.position == '0)
        else $error("position nonzero on a miss");

    a_cmp_then_read: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CMP |=> state_reg == S_READ)
        else $error("compare not followed by next probe");

endmodule

`default_nettype wire

// File: hdl/sorted_array_neighbor_search.sv
// top level: input decode, key store, search sequencer and result register
//
// input stream: s_tuser carries the function code (write, query lesser,
// query greater), s_tdata the slot, key, window low and window high.
// a write word stores its key and gives no result; an unused
// function code is dropped. a query word binary-searches the window
// and gives one result word: m_tuser is found, m_tdata the index.
// s_tready is high only while the sequencer is idle, so one query is
// worked at a time. each probe is a key store read, then the shared
// signed compares. while the sequencer is idle a new word can be taken
// every cycle, so writes stream; after a query the next word waits
// until the sequencer is back in idle. the result sits in an output
// register; a stalled m_tready holds it and the sequencer waits in its
// done state until the register frees up. reset returns the sequencer to
// idle and empties the output register; key store contents are not
// cleared and an entry reads as undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module sorted_array_neighbor_search (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // slot, key_value, window_low, window_high
    input  wire logic [sans_pkg::S_DATA_W-1:0]   s_tdata,
    // func
    input  wire logic [sans_pkg::FUNC_W-1:0]     s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // position
    output logic [sans_pkg::M_DATA_W-1:0]        m_tdata,
    // found
    output logic                                 m_tuser
);
    import sans_pkg::*;

    logic [IDX_W-1:0]        in_slot;
    logic signed [KEY_W-1:0] in_key;
    logic [IDX_W-1:0]        in_low;
    logic [IDX_W-1:0]        in_high;
    logic                    in_word;
    logic                    is_query;

    logic                    wr_en;
    logic [ADDR_W-1:0]       rd_addr;
    logic signed [KEY_W-1:0] rd_data;

    sans_req_t               req;
    logic                    start_ready;
    logic                    res_valid;
    logic                    res_ready;
    sans_res_t               res;

    logic                    m_valid_reg;
    logic                    m_found_reg;
    logic [IDX_W-1:0]        m_pos_reg;

    assign in_slot  = s_tdata[IDX_W-1:0];
    assign in_key   = $signed(s_tdata[IDX_W+KEY_W-1:IDX_W]);
    assign in_low   = s_tdata[2*IDX_W+KEY_W-1:IDX_W+KEY_W];
    assign in_high  = s_tdata[3*IDX_W+KEY_W-1:2*IDX_W+KEY_W];

    assign s_tready = start_ready;
    assign in_word  = s_tvalid && s_tready;
    assign is_query = (s_tuser == FUNC_LESSER) || (s_tuser == FUNC_GREATER);
    assign wr_en    = in_word && (s_tuser == FUNC_WRITE)
                      && ({1'b0, in_slot} < (IDX_W+1)'(DEPTH));

    assign req.want_greater = (s_tuser == FUNC_GREATER);
    assign req.target       = in_key;
    assign req.window_low   = in_low;
    assign req.window_high  = in_high;

    sans_key_ram u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (ADDR_W'(in_slot)),
        .wr_data (in_key),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    sans_search u_search (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start_valid (s_tvalid && is_query),
        .start_ready (start_ready),
        .req         (req),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_found_reg <= res.found;
            m_pos_reg   <= res.position;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_found_reg;
    assign m_tdata  = {{(M_DATA_W-IDX_W){1'b0}}, m_pos_reg};

endmodule

`default_nettype wire
